// ----- design/rrts_pkg.sv -----
// Shared codes and field widths for the round-robin task scheduler.
// Used by round_robin_task_scheduler_top; no dependencies.
package rrts_pkg;

    // Default sizing handed to the top level.
    localparam int MAX_TASKS_DEF = 16;
    localparam int ID_WIDTH_DEF  = 32;

    // Fixed widths of the stream fields.
    localparam int KIND_W     = 2;
    localparam int QID_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int ID_OUT_W   = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USED_W = 1 + SLOT_OUT_W + ID_OUT_W + SLOT_OUT_W + ID_OUT_W + 1;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    // Request kinds.
    localparam logic [KIND_W-1:0] K_CREATE  = 2'd0;
    localparam logic [KIND_W-1:0] K_EXIT    = 2'd1;
    localparam logic [KIND_W-1:0] K_RESCHED = 2'd2;
    localparam logic [KIND_W-1:0] K_QUERY   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] RS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] RS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] RS_FATAL  = 2'd2;
    localparam logic [STATUS_W-1:0] RS_HALTED = 2'd3;

    // Task states held per slot.
    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_DEAD    = 2'd2;

endpackage

// ----- design/round_robin_task_scheduler_top.sv -----
// Round-robin task scheduler: slot table in one memory, ring walks in a sequencer.
// Depends on rrts_pkg and rrts_slot_mem.
//
// One request is taken at a time and yields one result. The slot table sits in a
// single memory with one read and one write port, and every walk reads one slot per
// cycle through that read port, so the time a request takes follows the slots visited:
// create scans up from slot 0 to the lowest free slot, a query walks the ring from the
// head, a reschedule walks on from the current task to the next ready slot, and an exit
// that switches away adds the unlink walk from the ring head. A request while halted
// goes straight to the result with the halted status. No clearing pass follows reset.
// The next request is taken while a result still waits in the output register.
module round_robin_task_scheduler_top #(
    parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF,
    parameter int ID_WIDTH  = rrts_pkg::ID_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // query_id[31:0]
    input  logic [rrts_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // kind[1:0]
    input  logic [rrts_pkg::KIND_W-1:0]       i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // switched[0], current_slot[4:1], current_id[36:5], created_slot[40:37],
    // created_id[72:41], alive[73], zero[79:74]
    output logic [rrts_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // status[1:0]
    output logic [rrts_pkg::STATUS_W-1:0]     o_m_axis_tuser
);

    localparam int SLOT_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W    = $clog2(MAX_TASKS + 1);
    localparam int L_ID_LO  = SLOT_W;
    localparam int L_ST_LO  = SLOT_W + ID_WIDTH;
    localparam int L_USED   = L_ST_LO + 2;
    localparam int WORD_W   = L_USED + 1;
    localparam int CMP_W    = (ID_WIDTH > rrts_pkg::QID_W) ? ID_WIDTH : rrts_pkg::QID_W;
    localparam int OSLOT_W  = rrts_pkg::SLOT_OUT_W;
    localparam int OID_W    = rrts_pkg::ID_OUT_W;
    localparam int OPAD_W   = rrts_pkg::OUT_PAD_W;

    localparam logic [WORD_W-1:0] ENTRY0 =
        {1'b1, rrts_pkg::ST_RUNNING, {ID_WIDTH{1'b0}}, {SLOT_W{1'b0}}};

    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(MAX_TASKS - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TASKS - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CR_SCAN  = 4'd1;
    localparam logic [3:0] S_CR_HEAD  = 4'd2;
    localparam logic [3:0] S_CR_LINK  = 4'd3;
    localparam logic [3:0] S_RS_CUR   = 4'd4;
    localparam logic [3:0] S_RS_WALK  = 4'd5;
    localparam logic [3:0] S_RS_SETQ  = 4'd6;
    localparam logic [3:0] S_RS_OLD   = 4'd7;
    localparam logic [3:0] S_RS_MISS  = 4'd8;
    localparam logic [3:0] S_UL_ISSUE = 4'd9;
    localparam logic [3:0] S_UL_WALK  = 4'd10;
    localparam logic [3:0] S_UL_FREE  = 4'd11;
    localparam logic [3:0] S_QY_WALK  = 4'd12;
    localparam logic [3:0] S_PUSH     = 4'd13;

    function automatic logic [WORD_W-1:0] f_pack(
        input logic                used,
        input logic [1:0]          st,
        input logic [ID_WIDTH-1:0] id,
        input logic [SLOT_W-1:0]   link
    );
        return {used, st, id, link};
    endfunction

    // control state
    logic [3:0]              r_state,    n_state;
    logic [SLOT_W-1:0]       r_head,     n_head;
    logic [SLOT_W-1:0]       r_run_slot, n_run_slot;
    logic [ID_WIDTH-1:0]     r_run_id,   n_run_id;
    logic [ID_WIDTH-1:0]     r_id_ctr,   n_id_ctr;
    logic                    r_halted,   n_halted;
    logic                    r_m_tvalid, n_m_tvalid;

    // working and payload registers
    logic                    r_is_exit,  n_is_exit;
    logic [rrts_pkg::QID_W-1:0] r_qid,   n_qid;
    logic [SLOT_W-1:0]       r_p,        n_p;
    logic [CNT_W-1:0]        r_cnt,      n_cnt;
    logic [SLOT_W-1:0]       r_tslot,    n_tslot;
    logic [WORD_W-1:0]       r_word,     n_word;
    logic [WORD_W-1:0]       r_cur_word, n_cur_word;
    logic                    r_cur_dead, n_cur_dead;
    logic                    r_ul_found, n_ul_found;
    logic [rrts_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic                    r_res_sw,    n_res_sw;
    logic                    r_res_alive, n_res_alive;
    logic [SLOT_W-1:0]       r_res_cslot, n_res_cslot;
    logic [ID_WIDTH-1:0]     r_res_cid,   n_res_cid;
    logic [rrts_pkg::OUT_DATA_W-1:0] r_m_tdata, n_m_tdata;
    logic [rrts_pkg::STATUS_W-1:0]   r_m_tuser, n_m_tuser;

    // memory port
    logic                    w_wr_en;
    logic [SLOT_W-1:0]       w_wr_addr;
    logic [WORD_W-1:0]       w_wr_data;
    logic [SLOT_W-1:0]       w_rd_addr;
    logic [WORD_W-1:0]       w_rd_data;

    logic                    w_q_used;
    logic [1:0]              w_q_st;
    logic [ID_WIDTH-1:0]     w_q_id;
    logic [SLOT_W-1:0]       w_q_link;
    logic [SLOT_W-1:0]       w_cur_link;
    logic                    w_in_acc;

    rrts_slot_mem #(
        .DEPTH    (MAX_TASKS),
        .ADDR_W   (SLOT_W),
        .WIDTH    (WORD_W),
        .P_ENTRY0 (ENTRY0)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_q_used   = w_rd_data[L_USED];
    assign w_q_st     = w_rd_data[L_USED-1:L_ST_LO];
    assign w_q_id     = w_rd_data[L_ST_LO-1:L_ID_LO];
    assign w_q_link   = w_rd_data[SLOT_W-1:0];
    assign w_cur_link = r_cur_word[SLOT_W-1:0];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_run_slot   = r_run_slot;
        n_run_id     = r_run_id;
        n_id_ctr     = r_id_ctr;
        n_halted     = r_halted;
        n_m_tvalid   = r_m_tvalid;
        n_is_exit    = r_is_exit;
        n_qid        = r_qid;
        n_p          = r_p;
        n_cnt        = r_cnt;
        n_tslot      = r_tslot;
        n_word       = r_word;
        n_cur_word   = r_cur_word;
        n_cur_dead   = r_cur_dead;
        n_ul_found   = r_ul_found;
        n_res_status = r_res_status;
        n_res_sw     = r_res_sw;
        n_res_alive  = r_res_alive;
        n_res_cslot  = r_res_cslot;
        n_res_cid    = r_res_cid;
        n_m_tdata    = r_m_tdata;
        n_m_tuser    = r_m_tuser;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_p;
        w_wr_data    = r_word;
        w_rd_addr    = r_p;

        if (r_m_tvalid && i_m_axis_tready) begin
            n_m_tvalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_qid        = i_s_axis_tdata[rrts_pkg::QID_W-1:0];
                    n_is_exit    = (i_s_axis_tuser == rrts_pkg::K_EXIT);
                    n_res_status = rrts_pkg::RS_OK;
                    n_res_sw     = 1'b0;
                    n_res_alive  = 1'b0;
                    n_res_cslot  = '0;
                    n_res_cid    = '0;
                    n_cnt        = '0;
                    if (r_halted) begin
                        n_res_status = rrts_pkg::RS_HALTED;
                        n_state      = S_PUSH;
                    end else begin
                        unique case (i_s_axis_tuser)
                            rrts_pkg::K_CREATE: begin
                                w_rd_addr = '0;
                                n_p       = '0;
                                n_state   = S_CR_SCAN;
                            end
                            rrts_pkg::K_EXIT, rrts_pkg::K_RESCHED: begin
                                w_rd_addr = r_run_slot;
                                n_state   = S_RS_CUR;
                            end
                            rrts_pkg::K_QUERY: begin
                                w_rd_addr = r_head;
                                n_p       = r_head;
                                n_state   = S_QY_WALK;
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end
                end
            end

            // one slot per cycle: the read for the next slot goes out with the check
            S_CR_SCAN: begin
                if (!w_q_used) begin
                    n_tslot   = r_p;
                    w_rd_addr = r_head;
                    n_state   = S_CR_HEAD;
                end else if (r_p == LAST_SLOT) begin
                    n_res_status = rrts_pkg::RS_FULL;
                    n_state      = S_PUSH;
                end else begin
                    n_p       = r_p + 1'b1;
                    w_rd_addr = r_p + 1'b1;
                end
            end

            S_CR_HEAD: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_tslot;
                w_wr_data = f_pack(1'b1, rrts_pkg::ST_READY, r_id_ctr, w_q_link);
                // a head that is the new slot itself ends up pointing to itself
                if (r_head == r_tslot) begin
                    n_word = f_pack(1'b1, rrts_pkg::ST_READY, r_id_ctr, r_tslot);
                end else begin
                    n_word = {w_rd_data[WORD_W-1:SLOT_W], r_tslot};
                end
                n_state = S_CR_LINK;
            end

            S_CR_LINK: begin
                w_wr_en     = 1'b1;
                w_wr_addr   = r_head;
                w_wr_data   = r_word;
                n_res_cslot = r_tslot;
                n_res_cid   = r_id_ctr;
                n_id_ctr    = r_id_ctr + 1'b1;
                n_state     = S_PUSH;
            end

            S_RS_CUR: begin
                n_cur_word = w_rd_data;
                n_cur_dead = r_is_exit || (w_q_st == rrts_pkg::ST_DEAD);
                if (w_q_link == r_run_slot) begin
                    n_state = S_RS_MISS;
                end else begin
                    w_rd_addr = w_q_link;
                    n_p       = w_q_link;
                    n_state   = S_RS_WALK;
                end
            end

            S_RS_WALK: begin
                if (w_q_st == rrts_pkg::ST_READY) begin
                    n_tslot = r_p;
                    n_word  = f_pack(w_q_used, rrts_pkg::ST_RUNNING, w_q_id, w_q_link);
                    n_state = S_RS_SETQ;
                end else if (r_cnt == LAST_CNT || w_q_link == r_run_slot) begin
                    n_state = S_RS_MISS;
                end else begin
                    n_cnt     = r_cnt + 1'b1;
                    n_p       = w_q_link;
                    w_rd_addr = w_q_link;
                end
            end

            S_RS_MISS: begin
                if (r_cur_dead) begin
                    n_halted     = 1'b1;
                    n_res_status = rrts_pkg::RS_FATAL;
                end
                n_state = S_PUSH;
            end

            S_RS_SETQ: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_tslot;
                w_wr_data = r_word;
                n_state   = r_cur_dead ? S_UL_ISSUE : S_RS_OLD;
            end

            S_RS_OLD: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_run_slot;
                w_wr_data  = {r_cur_word[L_USED], rrts_pkg::ST_READY,
                              r_cur_word[L_ST_LO-1:0]};
                n_run_slot = r_tslot;
                n_run_id   = r_word[L_ST_LO-1:L_ID_LO];
                n_res_sw   = 1'b1;
                n_state    = S_PUSH;
            end

            // read the head only after the new task's write has landed
            S_UL_ISSUE: begin
                w_rd_addr  = r_head;
                n_p        = r_head;
                n_cnt      = '0;
                n_ul_found = 1'b0;
                n_state    = S_UL_WALK;
            end

            S_UL_WALK: begin
                if (w_q_link == r_run_slot) begin
                    w_wr_en    = 1'b1;
                    w_wr_addr  = r_p;
                    w_wr_data  = {w_rd_data[WORD_W-1:SLOT_W], w_cur_link};
                    n_ul_found = 1'b1;
                    if (r_head == r_run_slot) begin
                        n_head = (w_cur_link == r_run_slot) ? '0 : w_cur_link;
                    end
                    n_state = S_UL_FREE;
                end else if (r_cnt == LAST_CNT || w_q_link == r_head) begin
                    n_state = S_UL_FREE;
                end else begin
                    n_cnt     = r_cnt + 1'b1;
                    n_p       = w_q_link;
                    w_rd_addr = w_q_link;
                end
            end

            S_UL_FREE: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_run_slot;
                w_wr_data  = f_pack(1'b0, rrts_pkg::ST_READY,
                                    r_cur_word[L_ST_LO-1:L_ID_LO],
                                    r_ul_found ? r_run_slot : w_cur_link);
                n_run_slot = r_tslot;
                n_run_id   = r_word[L_ST_LO-1:L_ID_LO];
                n_res_sw   = 1'b1;
                n_state    = S_PUSH;
            end

            S_QY_WALK: begin
                if (w_q_used && (CMP_W'(w_q_id) == CMP_W'(r_qid))
                        && (w_q_st != rrts_pkg::ST_DEAD)) begin
                    n_res_alive = 1'b1;
                    n_state     = S_PUSH;
                end else if (r_cnt == LAST_CNT || w_q_link == r_head) begin
                    n_state = S_PUSH;
                end else begin
                    n_cnt     = r_cnt + 1'b1;
                    n_p       = w_q_link;
                    w_rd_addr = w_q_link;
                end
            end

            // hold the result until the output register is free
            S_PUSH: begin
                if (!r_m_tvalid || i_m_axis_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tuser  = r_res_status;
                    n_m_tdata  = {{OPAD_W{1'b0}}, r_res_alive,
                                  OID_W'(r_res_cid), OSLOT_W'(r_res_cslot),
                                  OID_W'(r_run_id), OSLOT_W'(r_run_slot), r_res_sw};
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_run_slot <= '0;
            r_run_id   <= '0;
            r_id_ctr   <= ID_WIDTH'(1);
            r_halted   <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_run_slot <= n_run_slot;
            r_run_id   <= n_run_id;
            r_id_ctr   <= n_id_ctr;
            r_halted   <= n_halted;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_exit    <= n_is_exit;
        r_qid        <= n_qid;
        r_p          <= n_p;
        r_cnt        <= n_cnt;
        r_tslot      <= n_tslot;
        r_word       <= n_word;
        r_cur_word   <= n_cur_word;
        r_cur_dead   <= n_cur_dead;
        r_ul_found   <= n_ul_found;
        r_res_status <= n_res_status;
        r_res_sw     <= n_res_sw;
        r_res_alive  <= n_res_alive;
        r_res_cslot  <= n_res_cslot;
        r_res_cid    <= n_res_cid;
        r_m_tdata    <= n_m_tdata;
        r_m_tuser    <= n_m_tuser;
    end

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag cleared without reset");

    a_halted_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == rrts_pkg::RS_HALTED)) |-> r_halted)
        else $error("halted status reported while not halted");

    a_switch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |-> (o_m_axis_tuser == rrts_pkg::RS_OK))
        else $error("task switch reported with an error status");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) || (r_state == S_PUSH)) |-> !w_wr_en)
        else $error("slot table written outside request processing");

endmodule

// ----- design/rrts_slot_mem.sv -----
// Slot table memory: one write port, one registered read port, per-entry valid bits.
// An entry never written reads as its reset word. No package dependency.
module rrts_slot_mem #(
    parameter int               DEPTH    = 16,
    parameter int               ADDR_W   = 4,
    parameter int               WIDTH    = 39,
    parameter logic [WIDTH-1:0] P_ENTRY0 = '0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_q;
    logic             r_q_valid;
    logic             r_q_zero;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q      <= r_mem[i_rd_addr];
        r_q_zero <= (i_rd_addr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            r_q_valid <= r_valid[i_rd_addr];
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    // Slot zero starts out as the running task; every other slot starts free.
    assign o_rd_data = r_q_valid ? r_q : (r_q_zero ? P_ENTRY0 : '0);

endmodule
